### rtl/ptft_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task flag timer package
// Sizes, request codes and controller states shared by the timer block.
// ----------------------------------------------------------------------------
package ptft_pkg;

  localparam int TASK_COUNT = 8;
  localparam int COUNT_BITS = 32;

  localparam int IDX_BITS   = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CNT_BITS   = $clog2(TASK_COUNT + 1);
  localparam int ENTRY_BITS = 2 * COUNT_BITS;

  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_PROGRAM = 3'd1;
  localparam logic [2:0] FN_SET_EN  = 3'd2;
  localparam logic [2:0] FN_READ_EN = 3'd3;
  localparam logic [2:0] FN_CONSUME = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_EXEC
  } ptft_state_t;

endpackage

### rtl/ptft_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptft_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/periodic_task_flag_timer_top.sv
// ----------------------------------------------------------------------------
// Periodic task flag timer
// Program, set enable, read enable and consume run in the execute state and
// give their result as it leaves, once the output is free; a tick first walks
// the reload/countdown RAM, one entry per cycle, then gives its result the same
// way. A new request is taken only in idle, after the last result is issued.
// Reset clears enables, pending flags and entry valid bits at once; no sweep.
// ----------------------------------------------------------------------------
module periodic_task_flag_timer_top
  import ptft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [2:0]  task_index,
  input  logic [31:0] period,
  input  logic        enable_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        answer
);

  ptft_state_t state, state_next;

  logic [2:0]            req_func;
  logic                  req_idx_ok;
  logic [IDX_BITS-1:0]   req_addr;
  logic [COUNT_BITS-1:0] req_reload;
  logic                  req_en;

  logic [CNT_BITS-1:0]   cnt;
  logic [IDX_BITS-1:0]   proc_addr;

  logic [TASK_COUNT-1:0] entry_ok;
  logic [TASK_COUNT-1:0] enabled;
  logic [TASK_COUNT-1:0] pending;

  logic                  mem_wr_en;
  logic [IDX_BITS-1:0]   mem_wr_addr;
  logic [ENTRY_BITS-1:0] mem_wr_data;
  logic [IDX_BITS-1:0]   mem_rd_addr;
  logic [ENTRY_BITS-1:0] mem_rd_data;

  logic [ENTRY_BITS-1:0] entry;
  logic [COUNT_BITS-1:0] ent_reload;
  logic [COUNT_BITS-1:0] ent_count;
  logic                  cnt_zero;
  logic                  cnt_busy;
  logic                  cnt_last;
  logic                  out_free;
  logic                  ans;

  logic [6:0]            idx_wide;
  logic [31:0]           period_m1;

  assign idx_wide  = {4'd0, task_index};
  assign period_m1 = period - 32'd1;

  assign entry      = entry_ok[proc_addr] ? mem_rd_data : '0;
  assign ent_reload = entry[ENTRY_BITS-1:COUNT_BITS];
  assign ent_count  = entry[COUNT_BITS-1:0];
  assign cnt_zero   = (ent_count == '0);
  assign cnt_busy   = (cnt != '0);
  assign cnt_last   = (cnt == CNT_BITS'(TASK_COUNT));
  assign out_free   = !out_valid || out_ready;

  ptft_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TASK_COUNT),
    .ADDR_W(IDX_BITS)
  ) u_entry_ram (
    .clk(clk),
    .wr_en(mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = proc_addr;
    mem_wr_data = {ent_reload, cnt_zero ? ent_reload : ent_count - COUNT_BITS'(1)};
    mem_rd_addr = cnt[IDX_BITS-1:0];
    ans         = 1'b0;
    unique case (req_func)
      FN_READ_EN: ans = req_idx_ok && enabled[req_addr];
      FN_CONSUME: ans = req_idx_ok && pending[req_addr];
      default:    ans = 1'b0;
    endcase
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (func == FN_TICK) ? ST_TICK : ST_EXEC;
        end
      end
      ST_TICK: begin
        if (cnt_busy) begin
          mem_wr_en = enabled[proc_addr];
        end
        if (cnt_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (req_func == FN_PROGRAM && req_idx_ok) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = req_addr;
            mem_wr_data = {req_reload, req_reload};
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_func   <= func;
      req_idx_ok <= (idx_wide < 7'(TASK_COUNT));
      req_addr   <= idx_wide[IDX_BITS-1:0];
      req_reload <= period_m1[COUNT_BITS-1:0];
      req_en     <= enable_value;
    end
    if (state == ST_TICK) begin
      proc_addr <= cnt[IDX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      entry_ok  <= '0;
      enabled   <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
      answer    <= 1'b0;
    end else begin
      if (state == ST_EXEC && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (mem_wr_en) begin
        entry_ok[mem_wr_addr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
        end
        ST_TICK: begin
          cnt <= cnt + CNT_BITS'(1);
          if (cnt_busy) begin
            if (!enabled[proc_addr]) begin
              pending[proc_addr] <= 1'b0;
            end else if (cnt_zero) begin
              pending[proc_addr] <= 1'b1;
            end
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            answer <= ans;
            if (req_idx_ok) begin
              unique case (req_func)
                FN_PROGRAM: enabled[req_addr] <= 1'b1;
                FN_SET_EN:  enabled[req_addr] <= req_en;
                FN_CONSUME: pending[req_addr] <= 1'b0;
                default:    ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
